// ===== hw/rtl/rcpsc_pkg.sv =====
// Shared types and constants for the RC pulse to signed command core.
// Request codes, sequencer states, register indexes and reset values.
// No dependencies.
`default_nettype none

package rcpsc_pkg;

    localparam int PULSE_WIDTH_DEF   = 16;
    localparam int STARTUP_ZEROS_DEF = 10;

    localparam int RAW_W     = 16;
    localparam int CMD_W     = 16;
    localparam int MAXOUT_W  = 15;
    localparam int FRAC_W    = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 1;

    localparam logic [MAXOUT_W-1:0] MAX_OUTPUT_RST       = 15'd1000;
    localparam logic [FRAC_W-1:0]   NEUTRAL_FRACTION_RST = 16'd3277;

    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_OUTPUT       = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_NEUTRAL_FRACTION = 1'b1;

    typedef enum logic [1:0] {
        REQ_READ        = 2'd0,
        REQ_CAL_ZERO    = 2'd1,
        REQ_CAL_RANGE   = 2'd2,
        REQ_RESET_RANGE = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HALF,
        ST_SELECT,
        ST_SCALE,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rc_pulse_to_signed_command_core.sv =====
// RC pulse to signed command core: calibration state, dead band, mapping.
// One shared multiplier and a restoring divider under a small sequencer.
// Depends on rcpsc_pkg.
//
// Usage:
//   Input channel (s_valid/s_ready) carries a request type and a measured
//   pulse width. Every request returns exactly one result on the m_ channel:
//   the signed command for a read, zero otherwise, plus the calibration
//   flags for a calibrate-range request.
//   The block takes one item at a time. Calibration and reset-range requests
//   go straight from idle to the finish state. A read passes the half-band
//   multiply and the select state; one in the dead band, or with a zero span
//   or offset, then finishes, while any other goes on to the scale multiply
//   and the bit-serial divider, which retires one quotient bit per cycle over
//   PULSE_WIDTH + 15 bits, and then finishes.
//   s_ready is high again in the cycle after the result is loaded into the
//   output register, so a new item is taken while that result waits.
//   If the receiver stalls with a result still held, the next item runs to
//   its end and waits there until the output register frees up.
//   Reset (aresetn low, synchronous) clears calibration to neutral 0,
//   range max 0 and min all ones, clears the start-up zero count and loads
//   max_output 1000 and neutral_fraction 3277. Writes on the cfg_ port take
//   effect at once and are meant for idle periods.
`default_nettype none

module rc_pulse_to_signed_command_core
    import rcpsc_pkg::*;
#(
    parameter int PULSE_WIDTH   = PULSE_WIDTH_DEF,
    parameter int STARTUP_ZEROS = STARTUP_ZEROS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,

    input  wire logic                    cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]   cfg_wdata,

    input  wire logic                    s_valid,
    output      logic                    s_ready,
    input  wire logic [1:0]              s_req_type,
    input  wire logic [RAW_W-1:0]        s_raw_pulse,

    output      logic                    m_valid,
    input  wire logic                    m_ready,
    output      logic signed [CMD_W-1:0] m_command,
    output      logic                    m_max_moved,
    output      logic                    m_min_moved
);

    localparam int W        = PULSE_WIDTH;
    localparam int MUL_W    = W + FRAC_W;
    localparam int NUM_W    = W + MAXOUT_W;
    localparam int CNT_W    = $clog2(NUM_W);
    localparam int V_W      = NUM_W + 2;
    localparam int STREAK_W = $clog2(STARTUP_ZEROS + 1);

    state_t state_reg, state_next;

    logic [MAXOUT_W-1:0] max_output_reg;
    logic [FRAC_W-1:0]   nfrac_reg;

    logic [W-1:0]        neutral_reg;
    logic [W-1:0]        low_reg;
    logic [W-1:0]        high_reg;
    logic [STREAK_W-1:0] streak_reg;

    req_t                req_reg;
    logic [W-1:0]        raw_reg;

    logic [MUL_W-1:0]    mul_reg;
    logic [W-1:0]        off_mag_reg;
    logic [W-1:0]        span_mag_reg;
    logic                q_neg_reg;
    logic                neg_branch_reg;
    logic [W-1:0]        rem_reg;
    logic [CNT_W-1:0]    cnt_reg;

    logic                    m_valid_reg;
    logic signed [CMD_W-1:0] m_command_reg;
    logic                    m_max_moved_reg;
    logic                    m_min_moved_reg;

    // control
    logic accept;
    logic fin_fire;
    logic mul_en;

    // select stage
    logic [W-1:0] half;
    logic         above_band;
    logic         below_band;
    logic         skip_div;
    logic [W:0]   off_s;
    logic [W:0]   span_s;
    logic [W-1:0] off_mag;
    logic [W-1:0] span_mag;

    // shared multiplier
    logic [W-1:0]      mul_a;
    logic [FRAC_W-1:0] mul_b;

    // divider step
    logic [W:0] rem_shift;
    logic       q_bit;

    // finish stage
    logic signed [V_W-1:0]   q_s;
    logic signed [V_W-1:0]   full_s;
    logic signed [V_W-1:0]   v_raw;
    logic signed [V_W-1:0]   v_clamp;
    logic signed [CMD_W-1:0] cmd_final;
    logic                    max_hit;
    logic                    min_hit;

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (req_t'(s_req_type) == REQ_READ) ? ST_HALF : ST_FINISH;
                end
            end
            ST_HALF:   state_next = ST_SELECT;
            ST_SELECT: state_next = skip_div ? ST_FINISH : ST_SCALE;
            ST_SCALE:  state_next = ST_DIVIDE;
            ST_DIVIDE: begin
                if (cnt_reg == '0) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (fin_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        mul_en   = 1'b0;
        fin_fire = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_ready  = 1'b1;
            ST_HALF:   mul_en   = 1'b1;
            ST_SCALE:  mul_en   = 1'b1;
            ST_FINISH: fin_fire = !m_valid_reg || m_ready;
            default: begin
            end
        endcase
    end

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_output_reg <= MAX_OUTPUT_RST;
            nfrac_reg      <= NEUTRAL_FRACTION_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_MAX_OUTPUT:       max_output_reg <= cfg_wdata[MAXOUT_W-1:0];
                CFG_NEUTRAL_FRACTION: nfrac_reg      <= cfg_wdata[FRAC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- select: dead band and span ----------------
    always_comb begin
        half       = mul_reg[MUL_W-1:FRAC_W];
        above_band = {1'b0, raw_reg} > ({1'b0, neutral_reg} + {1'b0, half});
        below_band = ({1'b0, raw_reg} + {1'b0, half}) < {1'b0, neutral_reg};
        if (above_band) begin
            off_s  = {1'b0, raw_reg}  - {1'b0, neutral_reg};
            span_s = {1'b0, high_reg} - {1'b0, neutral_reg};
        end else begin
            off_s  = {1'b0, raw_reg}     - {1'b0, low_reg};
            span_s = {1'b0, neutral_reg} - {1'b0, low_reg};
        end
        off_mag  = off_s[W]  ? W'(-off_s)  : off_s[W-1:0];
        span_mag = span_s[W] ? W'(-span_s) : span_s[W-1:0];
        skip_div = !(above_band || below_band) || (span_mag == '0) || (off_mag == '0);
    end

    // ---------------- shared multiplier and divider step ----------------
    assign mul_a = (state_reg == ST_HALF) ? high_reg : off_mag_reg;
    assign mul_b = (state_reg == ST_HALF) ? nfrac_reg : {1'b0, max_output_reg};

    assign rem_shift = {rem_reg, mul_reg[NUM_W-1]};
    assign q_bit     = rem_shift >= {1'b0, span_mag_reg};

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= req_t'(s_req_type);
            raw_reg <= W'(s_raw_pulse);
        end
        if (mul_en) begin
            mul_reg <= MUL_W'(mul_a) * MUL_W'(mul_b);
        end else if (state_reg == ST_SELECT) begin
            // hold a zero quotient when the divider is skipped
            if (skip_div) begin
                mul_reg <= '0;
            end
            off_mag_reg    <= off_mag;
            span_mag_reg   <= span_mag;
            q_neg_reg      <= off_s[W] ^ span_s[W];
            neg_branch_reg <= !above_band && below_band;
        end else if (state_reg == ST_DIVIDE) begin
            mul_reg <= {1'b0, mul_reg[NUM_W-2:0], q_bit};
        end
        if (state_reg == ST_SCALE) begin
            rem_reg <= '0;
            cnt_reg <= CNT_W'(NUM_W - 1);
        end else if (state_reg == ST_DIVIDE) begin
            // the remainder stays below the span, so it fits in W bits
            rem_reg <= W'(q_bit ? (rem_shift - {1'b0, span_mag_reg}) : rem_shift);
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (accept && req_t'(s_req_type) != REQ_READ) begin
            neg_branch_reg <= 1'b0;
            mul_reg        <= '0;
        end
    end

    // ---------------- finish: sign, offset, clamp ----------------
    always_comb begin
        q_s     = $signed({2'b00, mul_reg[NUM_W-1:0]});
        if (q_neg_reg) begin
            q_s = -q_s;
        end
        full_s  = $signed(V_W'(max_output_reg));
        v_raw   = neg_branch_reg ? (q_s - full_s) : q_s;
        v_clamp = v_raw;
        if (v_raw > full_s) begin
            v_clamp = full_s;
        end
        if (v_raw < -full_s) begin
            v_clamp = -full_s;
        end
        cmd_final = v_clamp[CMD_W-1:0];
        max_hit   = raw_reg >= high_reg;
        min_hit   = raw_reg <= low_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            neutral_reg <= '0;
            low_reg     <= '1;
            high_reg    <= '0;
            streak_reg  <= '0;
        end else if (fin_fire) begin
            case (req_reg)
                REQ_READ: begin
                    if (streak_reg < STREAK_W'(STARTUP_ZEROS)) begin
                        streak_reg <= (cmd_final == '0) ? streak_reg + 1'b1 : '0;
                    end
                end
                REQ_CAL_ZERO: neutral_reg <= raw_reg;
                REQ_CAL_RANGE: begin
                    if (max_hit) begin
                        high_reg <= raw_reg;
                    end
                    if (min_hit) begin
                        low_reg <= raw_reg;
                    end
                end
                default: begin
                    high_reg <= '0;
                    low_reg  <= '1;
                end
            endcase
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fin_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_fire) begin
            m_command_reg   <= '0;
            m_max_moved_reg <= 1'b0;
            m_min_moved_reg <= 1'b0;
            if (req_reg == REQ_READ) begin
                // suppress motion until the start-up run of neutral reads is seen
                if (streak_reg >= STREAK_W'(STARTUP_ZEROS)) begin
                    m_command_reg <= cmd_final;
                end
            end else if (req_reg == REQ_CAL_RANGE) begin
                m_max_moved_reg <= max_hit;
                m_min_moved_reg <= min_hit;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_command   = m_command_reg;
    assign m_max_moved = m_max_moved_reg;
    assign m_min_moved = m_min_moved_reg;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for rc_pulse_to_signed_command_core: directed and
// random calibrate/read traffic checked against an in-bench predictor.
// Depends on rcpsc_pkg and the core RTL.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcpsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_ITEMS    = 160;

    typedef struct packed {
        logic signed [CMD_W-1:0] command;
        logic                    max_moved;
        logic                    min_moved;
    } cmd_result_t;

    class pulse_command_tracker;
        logic [MAXOUT_W-1:0] max_out;
        logic [FRAC_W-1:0]   frac;
        logic [RAW_W-1:0]    neutral;
        logic [RAW_W-1:0]    low_pulse;
        logic [RAW_W-1:0]    high_pulse;
        logic [3:0]          zero_run;
        cmd_result_t         expected_q[$];
        int                  errors;

        function new();
            max_out    = MAX_OUTPUT_RST;
            frac       = NEUTRAL_FRACTION_RST;
            neutral    = '0;
            low_pulse  = '1;
            high_pulse = '0;
            zero_run   = '0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            if (addr == CFG_MAX_OUTPUT) begin
                max_out = data[MAXOUT_W-1:0];
            end else begin
                frac = data[FRAC_W-1:0];
            end
        endfunction

        // Zero-width span gives 0; division truncates toward zero.
        function longint scaled(longint offset, longint span, longint full);
            if (span == 0)
                return 0;
            return (offset * full) / span;
        endfunction

        function longint map_pulse(logic [RAW_W-1:0] raw);
            longint r, z, lo, hi, full, half, v;
            r    = longint'(raw);
            z    = longint'(neutral);
            lo   = longint'(low_pulse);
            hi   = longint'(high_pulse);
            full = longint'(max_out);
            half = (longint'(frac) * hi) >>> 16;
            if (r > z + half) begin
                v = scaled(r - z, hi - z, full);
            end else if (r < z - half) begin
                v = scaled(r - lo, z - lo, full) - full;
            end else begin
                v = 0;
            end
            if (v > full)
                v = full;
            if (v < -full)
                v = -full;
            return v;
        endfunction

        function void note_request(req_t req, logic [RAW_W-1:0] raw);
            cmd_result_t res;
            longint      v;
            res = '0;
            case (req)
                REQ_READ: begin
                    v = map_pulse(raw);
                    // Start-up guard: demand a run of neutral reads first.
                    if (zero_run < STARTUP_ZEROS_DEF) begin
                        if (v == 0) begin
                            zero_run++;
                        end else begin
                            zero_run = '0;
                            v = 0;
                        end
                    end
                    res.command = v[CMD_W-1:0];
                end
                REQ_CAL_ZERO: begin
                    neutral = raw;
                end
                REQ_CAL_RANGE: begin
                    if (raw >= high_pulse) begin
                        high_pulse    = raw;
                        res.max_moved = 1'b1;
                    end
                    if (raw <= low_pulse) begin
                        low_pulse     = raw;
                        res.min_moved = 1'b1;
                    end
                end
                default: begin
                    high_pulse = '0;
                    low_pulse  = '1;
                end
            endcase
            expected_q.push_back(res);
        endfunction

        function void check_result(logic signed [CMD_W-1:0] cmd, logic maxm, logic minm);
            cmd_result_t want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected: command %0d max %0b min %0b",
                         $time, cmd, maxm, minm);
                return;
            end
            want = expected_q.pop_front();
            if (cmd !== want.command) begin
                errors++;
                $display("%0t: command mismatch: expected %0d, actual %0d",
                         $time, want.command, cmd);
            end
            if (maxm !== want.max_moved) begin
                errors++;
                $display("%0t: max_moved mismatch: expected %0b, actual %0b",
                         $time, want.max_moved, maxm);
            end
            if (minm !== want.min_moved) begin
                errors++;
                $display("%0t: min_moved mismatch: expected %0b, actual %0b",
                         $time, want.min_moved, minm);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [CFG_ADDR_W-1:0]   cfg_addr;
    logic [CFG_DATA_W-1:0]   cfg_wdata;
    logic                    s_valid;
    logic                    s_ready;
    logic [1:0]              s_req_type;
    logic [RAW_W-1:0]        s_raw_pulse;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [CMD_W-1:0] m_command;
    logic                    m_max_moved;
    logic                    m_min_moved;

    pulse_command_tracker tracker = new();

    bit src_idle   = 1'b1;
    bit sink_stall = 1'b1;
    int stall_left = 0;
    int quiet      = 0;
    int sent       = 0;

    rc_pulse_to_signed_command_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_raw_pulse (s_raw_pulse),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_command   (m_command),
        .m_max_moved (m_max_moved),
        .m_min_moved (m_min_moved)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_left = 0;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (sink_stall && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_result(m_command, m_max_moved, m_min_moved);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Leave s_valid high between back-to-back items; drop it only for a gap.
    task automatic send_request(req_t rq, logic [RAW_W-1:0] raw);
        if (src_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_req_type  <= rq;
        s_raw_pulse <= raw;
        do @(posedge aclk); while (!s_ready);
        tracker.note_request(rq, raw);
        sent++;
    endtask

    task automatic send_noise();
        send_request(req_t'($urandom_range(0, 3)), RAW_W'($urandom_range(0, 65535)));
    endtask

    task automatic write_config(logic [CFG_DATA_W-1:0] max_val, logic [CFG_DATA_W-1:0] frac_val);
        // Drop the last transfer's valid so it is not taken again.
        s_valid <= 1'b0;
        // Hold writes until the core has gone idle.
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_MAX_OUTPUT;
        cfg_wdata <= max_val;
        @(posedge aclk);
        tracker.write_reg(CFG_MAX_OUTPUT, max_val);
        cfg_addr  <= CFG_NEUTRAL_FRACTION;
        cfg_wdata <= frac_val;
        @(posedge aclk);
        tracker.write_reg(CFG_NEUTRAL_FRACTION, frac_val);
        cfg_wr_en <= 1'b0;
    endtask

    // Calibrate a range and neutral, then read pulses around it.
    task automatic run_calibrated_reads();
        int span, center, lo, hi, a, b, n;
        case ($urandom_range(0, 5))
            0:       span = $urandom_range(0, 3);
            1, 2, 3: span = $urandom_range(20, 2000);
            default: span = $urandom_range(2000, 20000);
        endcase
        center = $urandom_range(span, 65535 - span);
        lo = center - span;
        hi = center + span;
        if ($urandom_range(0, 2) != 0)
            send_request(REQ_RESET_RANGE, RAW_W'($urandom_range(0, 65535)));
        if ($urandom_range(0, 1) == 0) begin
            send_request(REQ_CAL_RANGE, RAW_W'(lo));
            send_request(REQ_CAL_RANGE, RAW_W'(hi));
        end else begin
            send_request(REQ_CAL_RANGE, RAW_W'(hi));
            send_request(REQ_CAL_RANGE, RAW_W'(lo));
        end
        repeat ($urandom_range(0, 3))
            send_request(REQ_CAL_RANGE, RAW_W'($urandom_range(lo, hi)));
        if ($urandom_range(0, 7) == 0) begin
            // neutral anywhere, including outside the range (inverted spans)
            send_request(REQ_CAL_ZERO, RAW_W'($urandom_range(0, 65535)));
        end else begin
            send_request(REQ_CAL_ZERO, RAW_W'($urandom_range(lo, hi)));
        end
        a = lo - span / 2 - 4;
        b = hi + span / 2 + 4;
        if (a < 0)
            a = 0;
        if (b > 65535)
            b = 65535;
        n = $urandom_range(8, 30);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0:       send_noise();
                1:       send_request(REQ_READ, RAW_W'($urandom_range(0, 65535)));
                2:       send_request(REQ_READ, tracker.neutral);
                default: send_request(REQ_READ, RAW_W'($urandom_range(a, b)));
            endcase
        end
    endtask

    initial begin
        int ph, target;
        logic [CFG_DATA_W-1:0] max_val, frac_val;

        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_addr    <= CFG_MAX_OUTPUT;
        cfg_wdata   <= '0;
        s_valid     <= 1'b0;
        s_req_type  <= REQ_READ;
        s_raw_pulse <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: uncalibrated reads, range tracking, start-up guard,
        // dead band, clamping, degenerate and inverted spans.
        send_request(REQ_READ, 16'd0);
        send_request(REQ_READ, 16'hFFFF);
        send_request(REQ_CAL_RANGE, 16'd1000);
        send_request(REQ_CAL_RANGE, 16'd2000);
        send_request(REQ_CAL_RANGE, 16'd1000);
        send_request(REQ_CAL_ZERO, 16'd1500);
        send_request(REQ_READ, 16'd1900);
        repeat (10) send_request(REQ_READ, 16'd1500);
        send_request(REQ_READ, 16'd1900);
        send_request(REQ_READ, 16'd1100);
        send_request(REQ_READ, 16'hFFFF);
        send_request(REQ_READ, 16'd0);
        send_request(REQ_CAL_ZERO, 16'd2000);
        send_request(REQ_READ, 16'd2500);
        send_request(REQ_READ, 16'd1550);
        send_request(REQ_CAL_ZERO, 16'd2500);
        send_request(REQ_READ, 16'd2700);
        send_request(REQ_RESET_RANGE, 16'd1234);
        send_request(REQ_READ, 16'd3000);

        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                0: begin max_val = 16'd0;     frac_val = 16'd0;     end
                1: begin max_val = 16'd32767; frac_val = 16'hFFFF;  end
                2: begin max_val = 16'd32767; frac_val = 16'd0;     end
                3: begin max_val = 16'd0;     frac_val = 16'hFFFF;  end
                PHASE_COUNT - 1: begin
                    max_val  = CFG_DATA_W'(MAX_OUTPUT_RST);
                    frac_val = NEUTRAL_FRACTION_RST;
                end
                default: begin
                    max_val  = CFG_DATA_W'($urandom_range(0, 65535));
                    frac_val = CFG_DATA_W'($urandom_range(0, 65535));
                end
            endcase
            write_config(max_val, frac_val);
            target = sent + PHASE_ITEMS;
            while (sent < target) begin
                if (ph == PHASE_COUNT - 1) begin
                    src_idle   = 1'b0;
                    sink_stall = 1'b0;
                end else begin
                    src_idle   = ($urandom_range(0, 3) != 0);
                    sink_stall = ($urandom_range(0, 3) != 0);
                end
                if ($urandom_range(0, 6) == 0) begin
                    send_noise();
                end else begin
                    run_calibrated_reads();
                end
            end
        end

        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== rc_pulse_to_signed_command_core.f =====
hw/rtl/rcpsc_pkg.sv
hw/rtl/rc_pulse_to_signed_command_core.sv
dv/tb.sv
